/* rtl/core/hts_pkg.sv */
package hts_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [3:0] HEIGHT_SCALE_RST = 4'd5;
  localparam logic [7:0] TILE_WIDTH_RST   = 8'd64;

  // configuration register indexes
  localparam logic [0:0] REG_HEIGHT_SCALE = 1'b0;
  localparam logic [0:0] REG_TILE_WIDTH   = 1'b1;

  typedef struct packed {
    logic neg;
    logic zero;
  } hts_flags_t;

endpackage

/* rtl/core/hex_terrain_slope_shading_unit.sv */
// throughput: one request per cycle, set by the fully pipelined square-root
//   and divider cell rows, one result bit per cell
// reset: synchronous, clears all valid flags and loads the register defaults;
//   busy is high during reset only; the receiver cannot stall
module hex_terrain_slope_shading_unit import hts_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic signed [7:0] slope_left,
  input  logic signed [7:0] slope_right,
  input  logic signed [7:0] slope_top_left,
  input  logic signed [7:0] slope_top_right,
  input  logic signed [7:0] slope_bottom_left,
  input  logic signed [7:0] slope_bottom_right,
  input  logic              wr_en,
  input  logic [0:0]        wr_index,
  input  logic [7:0]        wr_data,
  output logic              done,
  output logic signed [7:0] shade
);

  localparam int F   = FRAC_BITS;
  localparam int LW  = F + 15;
  localparam int NW  = 2 * LW;
  localparam int RW  = LW + 2;
  localparam int PW  = F + 15;
  localparam int QW  = F + 2;
  localparam int DW  = LW + QW;
  localparam int MW  = 2 * F + 11;
  localparam int BW  = F + 11;
  localparam int LAT = 5 + LW + 1 + QW + 5;

  localparam longint S_L = (64'd86603 * (64'd1 << F) + 64'd50000) / 64'd100000;
  localparam longint V_L = (64'd57735 * (64'd1 << F) + 64'd50000) / 64'd100000;
  localparam logic [F-1:0]   S_C   = F'(S_L);
  localparam logic [F+6:0]   K_C   = (F+7)'(75 * V_L);
  localparam logic [2*F-1:0] S2_C  = (2*F)'(S_L * S_L);
  localparam logic [F-1:0]   S2_LO = S2_C[F-1:0];
  localparam logic [F-1:0]   S2_HI = S2_C[2*F-1:F];

  logic [3:0] height_scale;
  logic [7:0] tile_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_scale <= HEIGHT_SCALE_RST;
      tile_width   <= TILE_WIDTH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HEIGHT_SCALE: height_scale <= wr_data[3:0];
        REG_TILE_WIDTH:   tile_width   <= wr_data;
      endcase
    end
  end

  assign busy = rst;

  // front stages: scaled slopes, normal components, squares, radicand
  logic [4:0] fv;

  logic signed [11:0] s1_l, s1_r, s1_tl, s1_tr, s1_bl, s1_br;
  logic [7:0]         s1_tw;
  logic signed [14:0] s2_a;
  logic signed [13:0] s2_c;
  logic [7:0]         s2_tw;
  logic [27:0]        s3_asq;
  logic [25:0]        s3_csq;
  logic [15:0]        s3_twsq;
  logic signed [PW-1:0] s3_p, s4_p, s5_p;
  logic [NW-1:0]      s4_xz;
  logic [F+25:0]      s4_pplo, s4_pphi;
  logic [NW-1:0]      s5_n;

  logic signed [4:0]  hsx;
  logic signed [29:0] a_ext;
  logic signed [27:0] c_ext;
  logic signed [PW-1:0] y_p;

  always_comb begin
    hsx   = $signed({1'b0, height_scale});
    a_ext = 30'(s2_a);
    c_ext = 28'(s2_c);
    y_p   = PW'(s2_c) * $signed({1'b0, S_C});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      fv <= {fv[3:0], start && !busy};
    end
    s1_l  <= 12'(slope_left * hsx);
    s1_r  <= 12'(slope_right * hsx);
    s1_tl <= 12'(slope_top_left * hsx);
    s1_tr <= 12'(slope_top_right * hsx);
    s1_bl <= 12'(slope_bottom_left * hsx);
    s1_br <= 12'(slope_bottom_right * hsx);
    s1_tw <= tile_width;

    s2_a  <= 15'(2 * (15'(s1_r) - 15'(s1_l))) + 15'(s1_tr) - 15'(s1_tl)
             + 15'(s1_br) - 15'(s1_bl);
    s2_c  <= 14'(s1_bl) + 14'(s1_br) - 14'(s1_tl) - 14'(s1_tr);
    s2_tw <= s1_tw;

    s3_asq  <= 28'(a_ext * a_ext);
    s3_csq  <= 26'(c_ext * c_ext);
    s3_twsq <= {8'd0, s2_tw} * {8'd0, s2_tw};
    s3_p    <= y_p + $signed(PW'({s2_tw, {F{1'b0}}}))
               - $signed(PW'(a_ext <<< (F - 1)));

    // y squared is split into two partial products against the constant
    s4_pplo <= (F+26)'({F'(0), s3_csq} * {26'd0, S2_LO});
    s4_pphi <= (F+26)'({F'(0), s3_csq} * {26'd0, S2_HI});
    s4_xz   <= (NW'(s3_asq) << (2 * F - 2)) + (NW'(s3_twsq) << (2 * F));
    s4_p    <= s3_p;

    s5_n <= s4_xz + NW'(s4_pplo) + (NW'(s4_pphi) << F);
    s5_p <= s4_p;
  end

  // square-root cell row
  logic                 sq_v    [LW+1];
  logic [RW-1:0]        sq_rem  [LW+1];
  logic [LW-1:0]        sq_root [LW+1];
  logic [NW-1:0]        sq_nb   [LW+1];
  logic signed [PW-1:0] sq_p    [LW+1];

  assign sq_v[0]    = fv[4];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_nb[0]   = s5_n;
  assign sq_p[0]    = s5_p;

  for (genvar i = 0; i < LW; i++) begin : g_sqrt
    hts_sqrt_cell #(.LW(LW), .PW(PW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_v[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_nb    (sq_nb[i]),
      .in_p     (sq_p[i]),
      .out_valid(sq_v[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_nb   (sq_nb[i+1]),
      .out_p    (sq_p[i+1])
    );
  end

  // divider setup: magnitude of numerator times one
  logic [PW-1:0] p_mag;
  logic [DW-1:0] d_full;
  logic          ds_v;
  logic [LW-1:0] ds_rem, ds_den;
  logic [QW-1:0] ds_dv;
  hts_flags_t    ds_flags;

  always_comb begin
    p_mag  = sq_p[LW][PW-1] ? PW'(-sq_p[LW]) : PW'(sq_p[LW]);
    d_full = DW'(p_mag) << F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ds_v <= 1'b0;
    end else begin
      ds_v <= sq_v[LW];
    end
    ds_rem        <= d_full[DW-1:QW];
    ds_dv         <= d_full[QW-1:0];
    ds_den        <= sq_root[LW];
    ds_flags.neg  <= sq_p[LW][PW-1];
    ds_flags.zero <= (sq_root[LW] == '0);
  end

  // divider cell row
  logic          dv_v     [QW+1];
  logic [LW-1:0] dv_rem   [QW+1];
  logic [LW-1:0] dv_den   [QW+1];
  logic [QW-1:0] dv_dv    [QW+1];
  logic [QW-1:0] dv_q     [QW+1];
  hts_flags_t    dv_flags [QW+1];

  assign dv_v[0]     = ds_v;
  assign dv_rem[0]   = ds_rem;
  assign dv_den[0]   = ds_den;
  assign dv_dv[0]    = ds_dv;
  assign dv_q[0]     = '0;
  assign dv_flags[0] = ds_flags;

  for (genvar j = 0; j < QW; j++) begin : g_div
    hts_div_cell #(.LW(LW), .QW(QW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv_v[j]),
      .in_rem   (dv_rem[j]),
      .in_den   (dv_den[j]),
      .in_dv    (dv_dv[j]),
      .in_q     (dv_q[j]),
      .in_flags (dv_flags[j]),
      .out_valid(dv_v[j+1]),
      .out_rem  (dv_rem[j+1]),
      .out_den  (dv_den[j+1]),
      .out_dv   (dv_dv[j+1]),
      .out_q    (dv_q[j+1]),
      .out_flags(dv_flags[j+1])
    );
  end

  // back end: offset, scale, positive boost, saturate
  logic [3:0]          bv;
  logic signed [QW:0]  m1_q;
  logic signed [MW-1:0] m2_prod;
  logic signed [BW-1:0] b_val;
  logic signed [BW:0]   b2_val;

  logic signed [QW:0]   q_sgn;
  logic signed [MW-1:0] prod_adj;
  logic signed [BW+1:0] b_x3;
  logic signed [BW:0]   b2_adj;
  logic signed [BW-F:0] sh_full;
  logic signed [7:0]    sh_sat;

  always_comb begin
    q_sgn    = dv_flags[QW].neg ? -$signed({1'b0, dv_q[QW]}) : $signed({1'b0, dv_q[QW]});
    prod_adj = m2_prod + $signed({{(MW-F){1'b0}}, {F{m2_prod[MW-1]}}});
    b_x3     = (BW+2)'(b_val) + ((BW+2)'(b_val) <<< 1);
    b2_adj   = b2_val + $signed({{(BW+1-F){1'b0}}, {F{b2_val[BW]}}});
    sh_full  = b2_adj[BW:F];
    if (sh_full < -128) begin
      sh_sat = -8'sd128;
    end else if (sh_full > 127) begin
      sh_sat = 8'sd127;
    end else begin
      sh_sat = 8'(sh_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv   <= '0;
      done <= 1'b0;
    end else begin
      bv   <= {bv[2:0], dv_v[QW]};
      done <= bv[3];
    end
    // zero-length normal gives a flat shade
    m1_q    <= dv_flags[QW].zero ? '0 : q_sgn - $signed((QW+1)'(1) << F);
    m2_prod <= MW'(m1_q) * $signed({1'b0, K_C});
    b_val   <= prod_adj[MW-1:F];
    b2_val  <= (b_val > 0) ? (BW+1)'(b_x3 >>> 1) : (BW+1)'(b_val);
    shade   <= sh_sat;
  end

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  assert property (@(posedge clk) disable iff (rst)
    (dv_v[QW] && !dv_flags[QW].zero) |-> (dv_rem[QW] < dv_den[QW]))
    else $error("divider remainder not below normal length");

  assert property (@(posedge clk) disable iff (rst)
    (sq_v[LW] && sq_root[LW] == '0) |=> (ds_v && ds_flags.zero))
    else $error("zero normal length not flagged");

endmodule

/* rtl/core/hts_sqrt_cell.sv */
module hts_sqrt_cell import hts_pkg::*; #(
  parameter int LW = 31,
  parameter int PW = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [LW+1:0]        in_rem,
  input  logic [LW-1:0]        in_root,
  input  logic [2*LW-1:0]      in_nb,
  input  logic signed [PW-1:0] in_p,
  output logic                 out_valid,
  output logic [LW+1:0]        out_rem,
  output logic [LW-1:0]        out_root,
  output logic [2*LW-1:0]      out_nb,
  output logic signed [PW-1:0] out_p
);

  localparam int RW = LW + 2;
  localparam int NW = 2 * LW;

  logic [RW+1:0] cat;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          ge;

  // one root bit: bring down two radicand bits, try root*4+1
  always_comb begin
    cat   = {in_rem, in_nb[NW-1 -: 2]};
    trial = {2'b00, in_root, 2'b01};
    diff  = cat - trial;
    ge    = (cat >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= ge ? diff[RW-1:0] : cat[RW-1:0];
    out_root <= {in_root[LW-2:0], ge};
    out_nb   <= {in_nb[NW-3:0], 2'b00};
    out_p    <= in_p;
  end

endmodule

/* rtl/core/hts_div_cell.sv */
module hts_div_cell import hts_pkg::*; #(
  parameter int LW = 31,
  parameter int QW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [LW-1:0] in_rem,
  input  logic [LW-1:0] in_den,
  input  logic [QW-1:0] in_dv,
  input  logic [QW-1:0] in_q,
  input  hts_flags_t    in_flags,
  output logic          out_valid,
  output logic [LW-1:0] out_rem,
  output logic [LW-1:0] out_den,
  output logic [QW-1:0] out_dv,
  output logic [QW-1:0] out_q,
  output hts_flags_t    out_flags
);

  logic [LW:0] cat;
  logic [LW:0] diff;
  logic        ge;

  always_comb begin
    cat  = {in_rem, in_dv[QW-1]};
    diff = cat - {1'b0, in_den};
    ge   = (cat >= {1'b0, in_den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem   <= ge ? diff[LW-1:0] : cat[LW-1:0];
    out_den   <= in_den;
    out_dv    <= {in_dv[QW-2:0], 1'b0};
    out_q     <= {in_q[QW-2:0], ge};
    out_flags <= in_flags;
  end

endmodule
